>>> rtl/weighted_priority_scheduler_core_macros.svh
// Assertion helpers for the scheduler core.
`ifndef WEIGHTED_PRIORITY_SCHEDULER_CORE_MACROS_SVH
`define WEIGHTED_PRIORITY_SCHEDULER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle property check, off during reset.
`define WPS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent this cycle implies consequent next cycle.
`define WPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define WPS_ASSERT(lbl, clk, rst_n, prop, msg)

`define WPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> rtl/wps_pkg.sv
package wps_pkg;

    localparam int WPS_SLOTS = 16;

    localparam int PRIO_W = 16;
    localparam int NEED_W = 24;
    localparam int WORK_W = 25;
    localparam int KEY_W  = PRIO_W + WORK_W;
    localparam int STAT_W = 3;
    localparam int SLOT_W = 4;
    localparam int OCC_W  = 5;
    localparam int RUNS_W = 32;

    localparam logic OP_RUN = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] ST_ADDED   = 3'd0;
    localparam logic [STAT_W-1:0] ST_WAIT    = 3'd1;
    localparam logic [STAT_W-1:0] ST_DONE    = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd3;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd4;
    localparam logic [STAT_W-1:0] ST_BADPRIO = 3'd5;

    // commit kinds chosen by the controller
    localparam logic [2:0] MODE_ADD   = 3'd0;
    localparam logic [2:0] MODE_RUN   = 3'd1;
    localparam logic [2:0] MODE_FULL  = 3'd2;
    localparam logic [2:0] MODE_BAD   = 3'd3;
    localparam logic [2:0] MODE_EMPTY = 3'd4;

    typedef struct packed {
        logic              valid;
        logic [PRIO_W-1:0] prio;
        logic [NEED_W-1:0] need;
        logic [WORK_W-1:0] worked;
    } t_entry;

    typedef struct packed {
        logic       in_load;
        logic       clr_wr;
        logic       rd_en;
        logic       addr_inc;
        logic       addr_clr;
        logic       scan_clr;
        logic       commit;
        logic [2:0] mode;
    } t_dp_cmd;

    typedef struct packed {
        logic op_run;
        logic prio_zero;
        logic full;
        logic empty;
        logic addr_last;
        logic pipe_busy;
        logic out_free;
    } t_dp_stat;

endpackage

>>> rtl/wps_ctrl.sv
module wps_ctrl
    import wps_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_COMMIT = 3'd4;

    logic [2:0] r_state, n_state;
    logic [2:0] r_mode, n_mode;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        o_cmd      = '0;
        o_cmd.mode = r_mode;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.addr_last) begin
                    o_cmd.addr_clr = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.addr_inc = 1'b1;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.in_load = 1'b1;
                    n_state       = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_stat.op_run) begin
                    if (i_stat.empty) begin
                        n_mode  = MODE_EMPTY;
                        n_state = S_COMMIT;
                    end else begin
                        n_mode         = MODE_RUN;
                        o_cmd.scan_clr = 1'b1;
                        n_state        = S_SCAN;
                    end
                end else if (i_stat.full) begin
                    // full wins over a bad priority
                    n_mode  = MODE_FULL;
                    n_state = S_COMMIT;
                end else if (i_stat.prio_zero) begin
                    n_mode  = MODE_BAD;
                    n_state = S_COMMIT;
                end else begin
                    n_mode         = MODE_ADD;
                    o_cmd.scan_clr = 1'b1;
                    n_state        = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.rd_en = 1'b1;
                if (i_stat.addr_last) begin
                    o_cmd.addr_clr = 1'b1;
                    n_state        = S_COMMIT;
                end else begin
                    o_cmd.addr_inc = 1'b1;
                end
            end
            S_COMMIT: begin
                // wait for the scan pipe to drain and the result slot to open
                if (!i_stat.pipe_busy && i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_mode  <= MODE_ADD;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
        end
    end

endmodule

>>> rtl/wps_dp.sv
`include "weighted_priority_scheduler_core_macros.svh"

module wps_dp
    import wps_pkg::*;
#(
    parameter int SLOTS = WPS_SLOTS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    input  logic              i_op,
    input  logic [PRIO_W-1:0] i_prio,
    input  logic [NEED_W-1:0] i_need_time,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic [STAT_W-1:0] o_status,
    output logic [SLOT_W-1:0] o_slot,
    output logic [PRIO_W-1:0] o_ran_prio,
    output logic [WORK_W-1:0] o_done_time,
    output logic [RUNS_W-1:0] o_switch_count,
    output logic [OCC_W-1:0]  o_occupancy
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    t_entry r_mem [SLOTS];

    logic              r_op;
    logic [PRIO_W-1:0] r_prio;
    logic [NEED_W-1:0] r_need;

    logic [IW-1:0]     r_addr;

    t_entry            r_rd_data;
    logic              r_s1_vld;
    logic [IW-1:0]     r_s1_idx;
    logic              r_s2_vld;
    logic [IW-1:0]     r_s2_idx;
    t_entry            r_s2_ent;
    logic [KEY_W-1:0]  r_s2_key;

    logic              r_best_vld;
    logic [IW-1:0]     r_best_idx;
    logic [KEY_W-1:0]  r_best_key;
    t_entry            r_best_ent;
    logic              r_free_vld;
    logic [IW-1:0]     r_free_idx;

    logic [CW-1:0]     r_live, n_live;
    logic [RUNS_W-1:0] r_runs, n_runs;

    logic              r_out_vld;
    logic [STAT_W-1:0] r_out_status;
    logic [SLOT_W-1:0] r_out_slot;
    logic [PRIO_W-1:0] r_out_prio;
    logic [WORK_W-1:0] r_out_time;

    logic [WORK_W-1:0] s1_worked_inc;
    logic              take_best;
    logic              take_free;
    logic [WORK_W-1:0] run_time;
    logic              run_done;
    logic              is_add;
    logic              is_run;
    logic              out_free;
    logic              wr_en;
    logic [IW-1:0]     wr_idx;
    t_entry            wr_data;
    logic [IW+SLOT_W-1:0] free_ext;
    logic [IW+SLOT_W-1:0] best_ext;
    logic [CW+OCC_W-1:0]  occ_ext;

    assign is_add   = i_cmd.commit && (i_cmd.mode == MODE_ADD);
    assign is_run   = i_cmd.commit && (i_cmd.mode == MODE_RUN);
    assign out_free = !r_out_vld || !i_out_stall;

    assign s1_worked_inc = r_rd_data.worked + WORK_W'(1);

    assign take_best = r_s2_vld && r_s2_ent.valid &&
                       (!r_best_vld || (r_s2_key < r_best_key));
    assign take_free = r_s2_vld && !r_s2_ent.valid && !r_free_vld;

    assign run_time = r_best_ent.worked + WORK_W'(r_best_ent.prio);
    assign run_done = (run_time >= WORK_W'(r_best_ent.need));

    assign free_ext = {{SLOT_W{1'b0}}, r_free_idx};
    assign best_ext = {{SLOT_W{1'b0}}, r_best_idx};
    assign occ_ext  = {{OCC_W{1'b0}}, r_live};

    always_comb begin
        wr_en   = 1'b0;
        wr_idx  = r_addr;
        wr_data = '0;
        if (i_cmd.clr_wr) begin
            wr_en = 1'b1;
        end else if (is_add) begin
            wr_en          = 1'b1;
            wr_idx         = r_free_idx;
            wr_data.valid  = 1'b1;
            wr_data.prio   = r_prio;
            wr_data.need   = r_need;
            wr_data.worked = '0;
        end else if (is_run) begin
            wr_en          = 1'b1;
            wr_idx         = r_best_idx;
            wr_data.valid  = !run_done;
            wr_data.prio   = r_best_ent.prio;
            wr_data.need   = r_best_ent.need;
            wr_data.worked = run_time;
        end
    end

    always_comb begin
        n_live = r_live;
        n_runs = r_runs;
        if (is_add) begin
            n_live = r_live + CW'(1);
        end else if (is_run) begin
            if (run_done) begin
                n_live = r_live - CW'(1);
            end
            if (r_runs != '1) begin
                n_runs = r_runs + RUNS_W'(1);
            end
        end
    end

    // slot table, one read port for the scan and one write port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_idx] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr     <= '0;
            r_s1_vld   <= 1'b0;
            r_s2_vld   <= 1'b0;
            r_best_vld <= 1'b0;
            r_free_vld <= 1'b0;
            r_live     <= '0;
            r_runs     <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cmd.addr_clr) begin
                r_addr <= '0;
            end else if (i_cmd.addr_inc) begin
                r_addr <= r_addr + IW'(1);
            end
            r_s1_vld <= i_cmd.rd_en;
            r_s2_vld <= r_s1_vld;
            if (i_cmd.scan_clr) begin
                r_best_vld <= 1'b0;
                r_free_vld <= 1'b0;
            end else begin
                if (take_best) begin
                    r_best_vld <= 1'b1;
                end
                if (take_free) begin
                    r_free_vld <= 1'b1;
                end
            end
            r_live <= n_live;
            r_runs <= n_runs;
            if (i_cmd.commit) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_op   <= i_op;
            r_prio <= i_prio;
            r_need <= i_need_time;
        end
        r_s1_idx <= r_addr;
        if (r_s1_vld) begin
            r_s2_idx <= r_s1_idx;
            r_s2_ent <= r_rd_data;
            r_s2_key <= KEY_W'(r_rd_data.prio) * KEY_W'(s1_worked_inc);
        end
        if (take_best) begin
            r_best_idx <= r_s2_idx;
            r_best_key <= r_s2_key;
            r_best_ent <= r_s2_ent;
        end
        if (take_free) begin
            r_free_idx <= r_s2_idx;
        end
        if (i_cmd.commit) begin
            case (i_cmd.mode)
                MODE_ADD: begin
                    r_out_status <= ST_ADDED;
                    r_out_slot   <= free_ext[SLOT_W-1:0];
                    r_out_prio   <= '0;
                    r_out_time   <= '0;
                end
                MODE_RUN: begin
                    r_out_status <= run_done ? ST_DONE : ST_WAIT;
                    r_out_slot   <= best_ext[SLOT_W-1:0];
                    r_out_prio   <= r_best_ent.prio;
                    r_out_time   <= run_time;
                end
                MODE_FULL: begin
                    r_out_status <= ST_FULL;
                    r_out_slot   <= '0;
                    r_out_prio   <= '0;
                    r_out_time   <= '0;
                end
                MODE_BAD: begin
                    r_out_status <= ST_BADPRIO;
                    r_out_slot   <= '0;
                    r_out_prio   <= '0;
                    r_out_time   <= '0;
                end
                MODE_EMPTY: begin
                    r_out_status <= ST_EMPTY;
                    r_out_slot   <= '0;
                    r_out_prio   <= '0;
                    r_out_time   <= '0;
                end
                default: begin
                    r_out_status <= ST_EMPTY;
                    r_out_slot   <= '0;
                    r_out_prio   <= '0;
                    r_out_time   <= '0;
                end
            endcase
        end
    end

    assign o_stat.op_run    = (r_op == OP_RUN);
    assign o_stat.prio_zero = (r_prio == '0);
    assign o_stat.full      = (r_live == CW'(SLOTS));
    assign o_stat.empty     = (r_live == '0);
    assign o_stat.addr_last = (r_addr == IW'(SLOTS - 1));
    assign o_stat.pipe_busy = r_s1_vld || r_s2_vld;
    assign o_stat.out_free  = out_free;

    assign o_out_valid    = r_out_vld;
    assign o_status       = r_out_status;
    assign o_slot         = r_out_slot;
    assign o_ran_prio     = r_out_prio;
    assign o_done_time    = r_out_time;
    // both change only on a commit, which waits for the result register to free up
    assign o_switch_count = r_runs;
    assign o_occupancy    = occ_ext[OCC_W-1:0];

    `WPS_ASSERT(a_live_bound, i_clk, i_rst_n, r_live <= CW'(SLOTS), "occupancy above table size")
    `WPS_ASSERT(a_commit_drained, i_clk, i_rst_n, !i_cmd.commit || (!r_s1_vld && !r_s2_vld), "commit with scan in flight")
    `WPS_ASSERT(a_add_has_slot, i_clk, i_rst_n, !is_add || r_free_vld, "add commit without a free slot")
    `WPS_ASSERT(a_run_has_best, i_clk, i_rst_n, !is_run || r_best_vld, "run commit without a chosen entry")
    `WPS_ASSERT_NEXT(a_scan_clear, i_clk, i_rst_n, i_cmd.scan_clr, !r_best_vld && !r_free_vld, "scan flags not cleared")

endmodule

>>> rtl/weighted_priority_scheduler_core.sv
// Channel   Handshake                  Payload
// -------   ------------------------   ----------------------------------------------
// input     i_in_valid / o_in_stall    i_op, i_prio, i_need_time
// output    o_out_valid / i_out_stall  o_status, o_slot, o_ran_prio, o_done_time,
//                                      o_switch_count, o_occupancy
//
// An add that finds room and a run on a non-empty table scan the whole slot table:
// one slot table read per cycle for all SLOTS entries, then the read/multiply/compare
// pipe drains and the result commits. Rejected adds and empty runs skip the scan.
// After reset the table is swept to clear valid bits; input stalls meanwhile.
// A result waits in the output register while the next item is taken and scanned.
module weighted_priority_scheduler_core
    import wps_pkg::*;
#(
    parameter int SLOTS = WPS_SLOTS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_op,
    input  logic [PRIO_W-1:0] i_prio,
    input  logic [NEED_W-1:0] i_need_time,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [STAT_W-1:0] o_status,
    output logic [SLOT_W-1:0] o_slot,
    output logic [PRIO_W-1:0] o_ran_prio,
    output logic [WORK_W-1:0] o_done_time,
    output logic [RUNS_W-1:0] o_switch_count,
    output logic [OCC_W-1:0]  o_occupancy
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    wps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    wps_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .i_op           (i_op),
        .i_prio         (i_prio),
        .i_need_time    (i_need_time),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_slot         (o_slot),
        .o_ran_prio     (o_ran_prio),
        .o_done_time    (o_done_time),
        .o_switch_count (o_switch_count),
        .o_occupancy    (o_occupancy)
    );

endmodule
